@@ rtl/core/rfid_card_poll_sequencer_assert.svh @@
// Assertion macros for the checker file of the card poll sequencer.
`ifndef RFID_CARD_POLL_SEQUENCER_ASSERT_SVH
`define RFID_CARD_POLL_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define RCPS_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define RCPS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/rcps_pkg.sv @@
`default_nettype none

package rcps_pkg;

    // Receive byte cap and the widths that follow from it
    localparam int MAX_RX_BYTES = 18;
    localparam int RX_W         = $clog2(MAX_RX_BYTES + 1);
    localparam int ID_BYTES     = 5;

    // Result buffer holds the longest burst one item can cause
    localparam int RES_DEPTH    = 5;
    localparam int RES_W        = $clog2(RES_DEPTH + 1);
    localparam int RES_IDX_W    = $clog2(RES_DEPTH);

    // Configuration register indexes
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_CODE = 4'd1;
    localparam logic [19:0] POLL_LIMIT_RESET   = 20'd100000;
    localparam logic [7:0]  REQUEST_CODE_RESET = 8'h52;

    // Chip register addresses
    localparam logic [5:0] A_COMMAND    = 6'h01;
    localparam logic [5:0] A_IRQ_EN     = 6'h02;
    localparam logic [5:0] A_IRQ        = 6'h04;
    localparam logic [5:0] A_ERROR      = 6'h06;
    localparam logic [5:0] A_STATUS2    = 6'h08;
    localparam logic [5:0] A_FIFO_DATA  = 6'h09;
    localparam logic [5:0] A_FIFO_LEVEL = 6'h0A;
    localparam logic [5:0] A_CONTROL    = 6'h0C;
    localparam logic [5:0] A_FRAMING    = 6'h0D;
    localparam logic [5:0] A_COLL       = 6'h0E;
    localparam logic [5:0] A_TX_CONTROL = 6'h14;

    // Data values and masks
    localparam logic [7:0] CRYPTO_OFF_MASK = 8'hF7;
    localparam logic [7:0] IRQ_EN_ALL      = 8'hF7;
    localparam logic [7:0] LOW7_MASK       = 8'h7F;
    localparam logic [7:0] TOP_BIT         = 8'h80;
    localparam logic [7:0] TX_ANTENNA_ON   = 8'h03;
    localparam logic [7:0] FRAMING_7BIT    = 8'h07;
    localparam logic [7:0] FRAMING_8BIT    = 8'h00;
    localparam logic [7:0] CMD_IDLE        = 8'h00;
    localparam logic [7:0] CMD_TRANSCEIVE  = 8'h0C;
    localparam logic [7:0] ANTICOLL_SEL    = 8'h93;
    localparam logic [7:0] ANTICOLL_NVB    = 8'h20;
    localparam logic [7:0] IRQ_TIMER_MASK  = 8'h01;
    localparam logic [7:0] IRQ_DONE_MASK   = 8'h30;
    localparam logic [7:0] ERR_MASK        = 8'h1B;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REPORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        XFER_OK    = 2'd0,
        XFER_TIMER = 2'd1,
        XFER_ERR   = 2'd2
    } xfer_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ST2,
        ST_TXC,
        ST_COLL_CLR,
        ST_IRQ_CLR,
        ST_FIFO_FLUSH,
        ST_BF_SET,
        ST_POLL,
        ST_BF_CLR,
        ST_ERR,
        ST_LEVEL,
        ST_CTRL_BITS,
        ST_DATA,
        ST_CTRL_STOP,
        ST_COLL_SET
    } step_t;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] addr;
        logic [7:0] data;
    } res_t;

    function automatic res_t wr_res(input logic [5:0] addr, input logic [7:0] data);
        res_t r;
        r.kind = KIND_WRITE;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic res_t rd_res(input logic [5:0] addr);
        res_t r;
        r.kind = KIND_READ;
        r.addr = addr;
        r.data = 8'h00;
        return r;
    endfunction

    function automatic res_t report_res();
        res_t r;
        r.kind = KIND_REPORT;
        r.addr = 6'h00;
        r.data = 8'h00;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rfid_card_poll_sequencer.sv @@
`default_nettype none

// Card poll sequencer: a start item (command 0) runs a request transceive and
// then an anticollision transceive on the reader chip, as a series of register
// writes and read requests on the m_ side; each read request is the last result
// of its item, and the next data item (command 1) carries the value read back.
// The poll closes with one report carrying card_valid and the little-endian
// card id. An accepted item yields one to five results, one per cycle while m_ready
// is high, from a five-entry result buffer loaded in the accept cycle; the next
// item is taken in the cycle the previous item's last result transfers. Starts
// while busy and data while idle are dropped without results. Configuration is
// written on the cfg_ port, which is always ready.
module rfid_card_poll_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic [7:0]                         s_read_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_kind,
    output logic [5:0]                              m_reg_addr,
    output logic [7:0]                              m_write_data,
    output logic                                    m_card_valid,
    output logic [31:0]                             m_card_id,
    output logic                                    m_last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rcps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rcps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int RX_W = rcps_pkg::RX_W;

    // Configuration registers
    logic [19:0] poll_limit_reg;
    logic [7:0]  request_code_reg;

    // Sequencer state
    rcps_pkg::step_t step_reg, step_next;
    logic            anti_reg, anti_next;
    logic [19:0]     poll_count_reg, poll_count_next;
    logic [7:0]      last_irq_reg, last_irq_next;
    logic [RX_W-1:0] rx_total_reg, rx_total_next;
    logic [RX_W-1:0] rx_index_reg, rx_index_next;
    logic [7:0]      rx_bytes_reg [rcps_pkg::ID_BYTES];
    logic [7:0]      rx_bytes_next [rcps_pkg::ID_BYTES];
    rcps_pkg::xfer_t xfer_status_reg, xfer_status_next;

    // Result buffer
    rcps_pkg::res_t                  res_buf_reg [rcps_pkg::RES_DEPTH];
    logic [rcps_pkg::RES_W-1:0]      res_cnt_reg;
    logic [rcps_pkg::RES_IDX_W-1:0]  res_rd_reg;
    logic                            rep_valid_reg;
    logic [31:0]                     rep_id_reg;

    rcps_pkg::res_t                  new_res [rcps_pkg::RES_DEPTH];
    logic [rcps_pkg::RES_W-1:0]      new_cnt;
    logic                            rep_ok;
    logic [31:0]                     rep_id;

    logic            s_fire, m_fire, act;
    logic [7:0]      d;
    logic [19:0]     poll_dec;
    logic [7:0]      chk;
    logic [RX_W-1:0] rx_index_inc;
    rcps_pkg::res_t  head;

    assign d            = s_read_data;
    assign poll_dec     = poll_count_reg - 20'd1;
    assign rx_index_inc = rx_index_reg + RX_W'(1);
    assign s_fire       = s_valid && s_ready;
    assign m_fire       = m_valid && m_ready;

    // Take an item only when its command fits the current step
    assign act = (step_reg == rcps_pkg::ST_IDLE) ? (s_command == rcps_pkg::CMD_START)
                                                 : (s_command == rcps_pkg::CMD_DATA);

    // Check byte and id from the captured anticollision bytes
    assign chk    = rx_bytes_reg[0] ^ rx_bytes_reg[1] ^ rx_bytes_reg[2] ^ rx_bytes_reg[3];
    assign rep_ok = (xfer_status_reg == rcps_pkg::XFER_OK) && (chk == rx_bytes_reg[4]);
    assign rep_id = {rx_bytes_reg[3], rx_bytes_reg[2], rx_bytes_reg[1], rx_bytes_reg[0]};

    // Next state of the sequencer
    always_comb begin
        step_next        = step_reg;
        anti_next        = anti_reg;
        poll_count_next  = poll_count_reg;
        last_irq_next    = last_irq_reg;
        rx_total_next    = rx_total_reg;
        rx_index_next    = rx_index_reg;
        rx_bytes_next    = rx_bytes_reg;
        xfer_status_next = xfer_status_reg;
        unique case (step_reg)
            rcps_pkg::ST_IDLE: begin
                anti_next        = 1'b0;
                xfer_status_next = rcps_pkg::XFER_OK;
                step_next        = rcps_pkg::ST_ST2;
            end
            rcps_pkg::ST_ST2: begin
                step_next = anti_reg ? rcps_pkg::ST_COLL_CLR : rcps_pkg::ST_TXC;
            end
            rcps_pkg::ST_TXC:        step_next = rcps_pkg::ST_IRQ_CLR;
            rcps_pkg::ST_COLL_CLR:   step_next = rcps_pkg::ST_IRQ_CLR;
            rcps_pkg::ST_IRQ_CLR:    step_next = rcps_pkg::ST_FIFO_FLUSH;
            rcps_pkg::ST_FIFO_FLUSH: step_next = rcps_pkg::ST_BF_SET;
            rcps_pkg::ST_BF_SET: begin
                poll_count_next = poll_limit_reg;
                step_next       = rcps_pkg::ST_POLL;
            end
            rcps_pkg::ST_POLL: begin
                last_irq_next   = d;
                poll_count_next = poll_dec;
                if (poll_dec != 20'd0 && (d & rcps_pkg::IRQ_TIMER_MASK) == 8'h00
                        && (d & rcps_pkg::IRQ_DONE_MASK) == 8'h00) begin
                    step_next = rcps_pkg::ST_POLL;
                end else begin
                    step_next = rcps_pkg::ST_BF_CLR;
                end
            end
            rcps_pkg::ST_BF_CLR: begin
                if (poll_count_reg != 20'd0) begin
                    step_next = rcps_pkg::ST_ERR;
                end else begin
                    xfer_status_next = rcps_pkg::XFER_ERR;
                    step_next        = rcps_pkg::ST_CTRL_STOP;
                end
            end
            rcps_pkg::ST_ERR: begin
                if ((d & rcps_pkg::ERR_MASK) != 8'h00) begin
                    xfer_status_next = rcps_pkg::XFER_ERR;
                    step_next        = rcps_pkg::ST_CTRL_STOP;
                end else begin
                    xfer_status_next = ((last_irq_reg & rcps_pkg::IRQ_TIMER_MASK) != 8'h00)
                                       ? rcps_pkg::XFER_TIMER : rcps_pkg::XFER_OK;
                    for (int i = 0; i < rcps_pkg::ID_BYTES; i++) begin
                        rx_bytes_next[i] = 8'h00;
                    end
                    step_next = rcps_pkg::ST_LEVEL;
                end
            end
            rcps_pkg::ST_LEVEL: begin
                // Clamp the FIFO level to at least one and at most the cap
                if (d == 8'h00) begin
                    rx_total_next = RX_W'(1);
                end else if (d > 8'(rcps_pkg::MAX_RX_BYTES)) begin
                    rx_total_next = RX_W'(rcps_pkg::MAX_RX_BYTES);
                end else begin
                    rx_total_next = RX_W'(d);
                end
                rx_index_next = '0;
                step_next     = rcps_pkg::ST_CTRL_BITS;
            end
            rcps_pkg::ST_CTRL_BITS:  step_next = rcps_pkg::ST_DATA;
            rcps_pkg::ST_DATA: begin
                // Keep only the first bytes that make up id and check byte
                for (int i = 0; i < rcps_pkg::ID_BYTES; i++) begin
                    if (rx_index_reg == RX_W'(i)) begin
                        rx_bytes_next[i] = d;
                    end
                end
                rx_index_next = rx_index_inc;
                step_next = (rx_index_inc < rx_total_reg) ? rcps_pkg::ST_DATA
                                                          : rcps_pkg::ST_CTRL_STOP;
            end
            rcps_pkg::ST_CTRL_STOP: begin
                if (!anti_reg) begin
                    anti_next = 1'b1;
                    step_next = rcps_pkg::ST_ST2;
                end else begin
                    step_next = rcps_pkg::ST_COLL_SET;
                end
            end
            rcps_pkg::ST_COLL_SET: begin
                anti_next = 1'b0;
                step_next = rcps_pkg::ST_IDLE;
            end
            default: step_next = rcps_pkg::ST_IDLE;
        endcase
    end

    // Results caused by the current item
    always_comb begin
        for (int i = 0; i < rcps_pkg::RES_DEPTH; i++) begin
            new_res[i] = rcps_pkg::wr_res(6'h00, 8'h00);
        end
        new_cnt = '0;
        unique case (step_reg)
            rcps_pkg::ST_IDLE: begin
                new_res[0] = rcps_pkg::rd_res(rcps_pkg::A_STATUS2);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_ST2: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_STATUS2,
                                              d & rcps_pkg::CRYPTO_OFF_MASK);
                if (!anti_reg) begin
                    new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_FRAMING, rcps_pkg::FRAMING_7BIT);
                    new_res[2] = rcps_pkg::rd_res(rcps_pkg::A_TX_CONTROL);
                end else begin
                    new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_FRAMING, rcps_pkg::FRAMING_8BIT);
                    new_res[2] = rcps_pkg::rd_res(rcps_pkg::A_COLL);
                end
                new_cnt = 3'd3;
            end
            rcps_pkg::ST_TXC: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_TX_CONTROL,
                                              d | rcps_pkg::TX_ANTENNA_ON);
                new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_IRQ_EN, rcps_pkg::IRQ_EN_ALL);
                new_res[2] = rcps_pkg::rd_res(rcps_pkg::A_IRQ);
                new_cnt    = 3'd3;
            end
            rcps_pkg::ST_COLL_CLR: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_COLL, d & rcps_pkg::LOW7_MASK);
                new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_IRQ_EN, rcps_pkg::IRQ_EN_ALL);
                new_res[2] = rcps_pkg::rd_res(rcps_pkg::A_IRQ);
                new_cnt    = 3'd3;
            end
            rcps_pkg::ST_IRQ_CLR: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_IRQ, d & rcps_pkg::LOW7_MASK);
                new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_COMMAND, rcps_pkg::CMD_IDLE);
                new_res[2] = rcps_pkg::rd_res(rcps_pkg::A_FIFO_LEVEL);
                new_cnt    = 3'd3;
            end
            rcps_pkg::ST_FIFO_FLUSH: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_FIFO_LEVEL, d | rcps_pkg::TOP_BIT);
                if (anti_reg) begin
                    new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_FIFO_DATA, rcps_pkg::ANTICOLL_SEL);
                    new_res[2] = rcps_pkg::wr_res(rcps_pkg::A_FIFO_DATA, rcps_pkg::ANTICOLL_NVB);
                    new_res[3] = rcps_pkg::wr_res(rcps_pkg::A_COMMAND,
                                                  rcps_pkg::CMD_TRANSCEIVE);
                    new_res[4] = rcps_pkg::rd_res(rcps_pkg::A_FRAMING);
                    new_cnt    = 3'd5;
                end else begin
                    new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_FIFO_DATA, request_code_reg);
                    new_res[2] = rcps_pkg::wr_res(rcps_pkg::A_COMMAND,
                                                  rcps_pkg::CMD_TRANSCEIVE);
                    new_res[3] = rcps_pkg::rd_res(rcps_pkg::A_FRAMING);
                    new_cnt    = 3'd4;
                end
            end
            rcps_pkg::ST_BF_SET: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_FRAMING, d | rcps_pkg::TOP_BIT);
                new_res[1] = rcps_pkg::rd_res(rcps_pkg::A_IRQ);
                new_cnt    = 3'd2;
            end
            rcps_pkg::ST_POLL: begin
                new_res[0] = (step_next == rcps_pkg::ST_POLL)
                             ? rcps_pkg::rd_res(rcps_pkg::A_IRQ)
                             : rcps_pkg::rd_res(rcps_pkg::A_FRAMING);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_BF_CLR: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_FRAMING, d & rcps_pkg::LOW7_MASK);
                new_res[1] = (poll_count_reg != 20'd0) ? rcps_pkg::rd_res(rcps_pkg::A_ERROR)
                                                       : rcps_pkg::rd_res(rcps_pkg::A_CONTROL);
                new_cnt    = 3'd2;
            end
            rcps_pkg::ST_ERR: begin
                new_res[0] = ((d & rcps_pkg::ERR_MASK) != 8'h00)
                             ? rcps_pkg::rd_res(rcps_pkg::A_CONTROL)
                             : rcps_pkg::rd_res(rcps_pkg::A_FIFO_LEVEL);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_LEVEL: begin
                new_res[0] = rcps_pkg::rd_res(rcps_pkg::A_CONTROL);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_CTRL_BITS: begin
                new_res[0] = rcps_pkg::rd_res(rcps_pkg::A_FIFO_DATA);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_DATA: begin
                new_res[0] = (rx_index_inc < rx_total_reg)
                             ? rcps_pkg::rd_res(rcps_pkg::A_FIFO_DATA)
                             : rcps_pkg::rd_res(rcps_pkg::A_CONTROL);
                new_cnt    = 3'd1;
            end
            rcps_pkg::ST_CTRL_STOP: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_CONTROL, d | rcps_pkg::TOP_BIT);
                new_res[1] = rcps_pkg::wr_res(rcps_pkg::A_COMMAND, rcps_pkg::CMD_IDLE);
                new_res[2] = anti_reg ? rcps_pkg::rd_res(rcps_pkg::A_COLL)
                                      : rcps_pkg::rd_res(rcps_pkg::A_STATUS2);
                new_cnt    = 3'd3;
            end
            rcps_pkg::ST_COLL_SET: begin
                new_res[0] = rcps_pkg::wr_res(rcps_pkg::A_COLL, d | rcps_pkg::TOP_BIT);
                new_res[1] = rcps_pkg::report_res();
                new_cnt    = 3'd2;
            end
            default: new_cnt = '0;
        endcase
    end

    // Accept configuration at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg   <= rcps_pkg::POLL_LIMIT_RESET;
            request_code_reg <= rcps_pkg::REQUEST_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == rcps_pkg::CFG_POLL_LIMIT) begin
                poll_limit_reg <= cfg_data[19:0];
            end else if (cfg_index == rcps_pkg::CFG_REQUEST_CODE) begin
                request_code_reg <= cfg_data[7:0];
            end
        end
    end

    // Advance sequencer state on a matching input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= rcps_pkg::ST_IDLE;
            anti_reg        <= 1'b0;
            poll_count_reg  <= '0;
            last_irq_reg    <= '0;
            rx_total_reg    <= '0;
            rx_index_reg    <= '0;
            xfer_status_reg <= rcps_pkg::XFER_OK;
            for (int i = 0; i < rcps_pkg::ID_BYTES; i++) begin
                rx_bytes_reg[i] <= 8'h00;
            end
        end else if (s_fire && act) begin
            step_reg        <= step_next;
            anti_reg        <= anti_next;
            poll_count_reg  <= poll_count_next;
            last_irq_reg    <= last_irq_next;
            rx_total_reg    <= rx_total_next;
            rx_index_reg    <= rx_index_next;
            xfer_status_reg <= xfer_status_next;
            rx_bytes_reg    <= rx_bytes_next;
        end
    end

    // Result buffer control: reload on a new item, else drain one per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= '0;
            res_rd_reg  <= '0;
        end else if (s_fire && act) begin
            res_cnt_reg <= new_cnt;
            res_rd_reg  <= '0;
        end else if (m_fire) begin
            if (m_last) begin
                res_cnt_reg <= '0;
                res_rd_reg  <= '0;
            end else begin
                res_rd_reg <= res_rd_reg + rcps_pkg::RES_IDX_W'(1);
            end
        end
    end

    // Load result payload; no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire && act) begin
            res_buf_reg   <= new_res;
            rep_valid_reg <= rep_ok;
            rep_id_reg    <= rep_ok ? rep_id : 32'h0;
        end
    end

    // Drive the result channel from the buffer head
    assign head         = res_buf_reg[res_rd_reg];
    assign m_valid      = (res_cnt_reg != '0);
    assign m_last       = (rcps_pkg::RES_W'(res_rd_reg) == res_cnt_reg - rcps_pkg::RES_W'(1));
    assign m_kind       = head.kind;
    assign m_reg_addr   = head.addr;
    assign m_write_data = head.data;
    assign m_card_valid = (head.kind == rcps_pkg::KIND_REPORT) ? rep_valid_reg : 1'b0;
    assign m_card_id    = (head.kind == rcps_pkg::KIND_REPORT) ? rep_id_reg : 32'h0;

    // Take the next item once the buffer empties or its last result leaves
    assign s_ready = (res_cnt_reg == '0) || (m_fire && m_last);

endmodule

`default_nettype wire

@@ rtl/core/rcps_checker.sv @@
`default_nettype none

`include "rfid_card_poll_sequencer_assert.svh"

module rcps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_kind,
    input wire logic [5:0]  m_reg_addr,
    input wire logic [7:0]  m_write_data,
    input wire logic        m_card_valid,
    input wire logic [31:0] m_card_id,
    input wire logic        m_last
);

    // Result kind is one of the three defined codes
    `RCPS_ASSERT_NOW(a_kind_legal, aclk, aresetn, m_valid, m_kind == rcps_pkg::KIND_WRITE || m_kind == rcps_pkg::KIND_READ || m_kind == rcps_pkg::KIND_REPORT, "result kind out of range")

    // A report or a read request always closes its item's burst
    `RCPS_ASSERT_NOW(a_close_last, aclk, aresetn, m_valid && (m_kind == rcps_pkg::KIND_REPORT || m_kind == rcps_pkg::KIND_READ), m_last, "report or read request not marked last")

    // An invalid report or a register access carries no card id
    `RCPS_ASSERT_NOW(a_id_zero, aclk, aresetn, m_valid && !m_card_valid, m_card_id == 32'h0, "card id set without card valid")

    // Hold a stalled result
    `RCPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_reg_addr) && $stable(m_write_data) && $stable(m_last), "stalled result changed")

endmodule

bind rfid_card_poll_sequencer rcps_checker u_rcps_checker (.*);

`default_nettype wire

@@ bench/poll_scoreboard_pkg.sv @@
package poll_scoreboard_pkg;

    import rcps_pkg::*;

    // One chip access or poll report as seen on the m_ side
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  addr;
        logic [7:0]  data;
        logic        card_valid;
        logic [31:0] card_id;
        logic        last;
    } chip_access_t;

    class poll_scoreboard;

        // Register copies
        logic [19:0]  poll_limit;
        logic [7:0]   request_code;

        // Sequencer state as the block should hold it
        step_t        step;
        logic         in_anticoll;
        logic [19:0]  polls_left;
        logic [7:0]   last_irq;
        logic [4:0]   rx_total;
        logic [4:0]   rx_index;
        logic [7:0]   rx_bytes [5];
        xfer_t        status;

        chip_access_t expected_accesses [$];

        int items_taken;
        int checked;
        int mismatches;
        int reports;
        int good_reports;

        function new();
            poll_limit   = POLL_LIMIT_RESET;
            request_code = REQUEST_CODE_RESET;
            step         = ST_IDLE;
            in_anticoll  = 1'b0;
            polls_left   = '0;
            last_irq     = '0;
            rx_total     = '0;
            rx_index     = '0;
            status       = XFER_OK;
            foreach (rx_bytes[i]) rx_bytes[i] = '0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_POLL_LIMIT)
                poll_limit = value[19:0];
            else if (index == CFG_REQUEST_CODE)
                request_code = value[7:0];
        endfunction

        function void add_access(kind_t kind, logic [5:0] addr, logic [7:0] data,
                                 logic ok, logic [31:0] id);
            chip_access_t a;
            a.kind       = kind;
            a.addr       = addr;
            a.data       = data;
            a.card_valid = ok;
            a.card_id    = id;
            a.last       = 1'b0;
            expected_accesses.push_back(a);
        endfunction

        function void add_write(logic [5:0] addr, logic [7:0] data);
            add_access(KIND_WRITE, addr, data, 1'b0, '0);
        endfunction

        // A read request always closes the burst and names the step that takes its data
        function void add_read(logic [5:0] addr, step_t next);
            add_access(KIND_READ, addr, 8'h00, 1'b0, '0);
            step = next;
        endfunction

        function void start_transceive();
            add_write(A_IRQ_EN, IRQ_EN_ALL);
            add_read(A_IRQ, ST_IRQ_CLR);
        endfunction

        // Predict the accesses caused by one accepted item
        function void take_item(logic cmd, logic [7:0] d);
            int           n_prior;
            logic [7:0]   chk;
            logic         ok;
            chip_access_t a;
            n_prior = expected_accesses.size();
            items_taken++;
            if (step == ST_IDLE) begin
                if (cmd != CMD_START)
                    return;
                in_anticoll = 1'b0;
                status      = XFER_OK;
                add_read(A_STATUS2, ST_ST2);
            end else begin
                if (cmd != CMD_DATA)
                    return;
                case (step)
                    ST_ST2: begin
                        add_write(A_STATUS2, d & CRYPTO_OFF_MASK);
                        if (!in_anticoll) begin
                            add_write(A_FRAMING, FRAMING_7BIT);
                            add_read(A_TX_CONTROL, ST_TXC);
                        end else begin
                            add_write(A_FRAMING, FRAMING_8BIT);
                            add_read(A_COLL, ST_COLL_CLR);
                        end
                    end
                    ST_TXC: begin
                        add_write(A_TX_CONTROL, d | TX_ANTENNA_ON);
                        start_transceive();
                    end
                    ST_COLL_CLR: begin
                        add_write(A_COLL, d & LOW7_MASK);
                        start_transceive();
                    end
                    ST_IRQ_CLR: begin
                        add_write(A_IRQ, d & LOW7_MASK);
                        add_write(A_COMMAND, CMD_IDLE);
                        add_read(A_FIFO_LEVEL, ST_FIFO_FLUSH);
                    end
                    ST_FIFO_FLUSH: begin
                        add_write(A_FIFO_LEVEL, d | TOP_BIT);
                        if (in_anticoll) begin
                            add_write(A_FIFO_DATA, ANTICOLL_SEL);
                            add_write(A_FIFO_DATA, ANTICOLL_NVB);
                        end else begin
                            add_write(A_FIFO_DATA, request_code);
                        end
                        add_write(A_COMMAND, CMD_TRANSCEIVE);
                        add_read(A_FRAMING, ST_BF_SET);
                    end
                    ST_BF_SET: begin
                        add_write(A_FRAMING, d | TOP_BIT);
                        polls_left = poll_limit;
                        add_read(A_IRQ, ST_POLL);
                    end
                    ST_POLL: begin
                        // Counter wraps from zero, so a zero limit allows a full 2^20 polls
                        last_irq   = d;
                        polls_left = polls_left - 20'd1;
                        if (polls_left != 0 && (d & IRQ_TIMER_MASK) == 0 &&
                            (d & IRQ_DONE_MASK) == 0)
                            add_read(A_IRQ, ST_POLL);
                        else
                            add_read(A_FRAMING, ST_BF_CLR);
                    end
                    ST_BF_CLR: begin
                        add_write(A_FRAMING, d & LOW7_MASK);
                        if (polls_left != 0) begin
                            add_read(A_ERROR, ST_ERR);
                        end else begin
                            status = XFER_ERR;
                            add_read(A_CONTROL, ST_CTRL_STOP);
                        end
                    end
                    ST_ERR: begin
                        if ((d & ERR_MASK) != 0) begin
                            status = XFER_ERR;
                            add_read(A_CONTROL, ST_CTRL_STOP);
                        end else begin
                            status = ((last_irq & IRQ_TIMER_MASK) != 0) ? XFER_TIMER : XFER_OK;
                            foreach (rx_bytes[i]) rx_bytes[i] = '0;
                            add_read(A_FIFO_LEVEL, ST_LEVEL);
                        end
                    end
                    ST_LEVEL: begin
                        if (d == 0)
                            rx_total = 5'd1;
                        else if (d > MAX_RX_BYTES)
                            rx_total = 5'(MAX_RX_BYTES);
                        else
                            rx_total = d[4:0];
                        rx_index = '0;
                        add_read(A_CONTROL, ST_CTRL_BITS);
                    end
                    ST_CTRL_BITS: begin
                        add_read(A_FIFO_DATA, ST_DATA);
                    end
                    ST_DATA: begin
                        // Keep the first five bytes only
                        if (rx_index < 5)
                            rx_bytes[rx_index] = d;
                        rx_index = rx_index + 5'd1;
                        if (rx_index < rx_total)
                            add_read(A_FIFO_DATA, ST_DATA);
                        else
                            add_read(A_CONTROL, ST_CTRL_STOP);
                    end
                    ST_CTRL_STOP: begin
                        add_write(A_CONTROL, d | TOP_BIT);
                        add_write(A_COMMAND, CMD_IDLE);
                        if (!in_anticoll) begin
                            in_anticoll = 1'b1;
                            add_read(A_STATUS2, ST_ST2);
                        end else begin
                            add_read(A_COLL, ST_COLL_SET);
                        end
                    end
                    ST_COLL_SET: begin
                        chk = rx_bytes[0] ^ rx_bytes[1] ^ rx_bytes[2] ^ rx_bytes[3];
                        ok  = (status == XFER_OK) && (chk == rx_bytes[4]);
                        add_write(A_COLL, d | TOP_BIT);
                        add_access(KIND_REPORT, 6'h00, 8'h00, ok,
                                   ok ? {rx_bytes[3], rx_bytes[2], rx_bytes[1], rx_bytes[0]}
                                      : 32'h0);
                        reports++;
                        if (ok)
                            good_reports++;
                        step        = ST_IDLE;
                        in_anticoll = 1'b0;
                    end
                    default: begin
                        step = ST_IDLE;
                    end
                endcase
            end
            // Flag the final access of the burst
            if (expected_accesses.size() > n_prior) begin
                a      = expected_accesses.pop_back();
                a.last = 1'b1;
                expected_accesses.push_back(a);
            end
        endfunction

        // Compare one result transfer against the oldest prediction
        function void check_access(logic [1:0] kind, logic [5:0] addr, logic [7:0] data,
                                   logic card_valid, logic [31:0] card_id, logic last);
            chip_access_t e;
            if (expected_accesses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d addr 0x%02h data 0x%02h",
                             kind, addr, data);
                return;
            end
            e = expected_accesses.pop_front();
            checked++;
            if (kind !== e.kind || addr !== e.addr || data !== e.data ||
                card_valid !== e.card_valid || card_id !== e.card_id || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d expected: kind %0d addr 0x%02h data 0x%02h valid %0b id 0x%08h last %0b",
                             checked, e.kind, e.addr, e.data, e.card_valid, e.card_id, e.last);
                    $display("result %0d actual:   kind %0d addr 0x%02h data 0x%02h valid %0b id 0x%08h last %0b",
                             checked, kind, addr, data, card_valid, card_id, last);
                end
            end
        endfunction

    endclass

endpackage

@@ bench/rfid_card_poll_sequencer_tb.sv @@
module rfid_card_poll_sequencer_tb;

    import rcps_pkg::*;
    import poll_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 22;

    // Data for the directed walk through one whole poll, after the start
    localparam logic [7:0] WALK_DATA [23] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h31, 8'h80, 8'hE4, 8'h00, 8'h5A, 8'hAA,
        8'h01, 8'h08, 8'h80, 8'h7F, 8'hFF, 8'h00, 8'h20, 8'h00, ERR_MASK, 8'hFF, 8'h00
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [7:0]             s_read_data;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_kind;
    logic [5:0]             m_reg_addr;
    logic [7:0]             m_write_data;
    logic                   m_card_valid;
    logic [31:0]            m_card_id;
    logic                   m_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    poll_scoreboard sb;
    int  cycle_count;
    int  random_items;
    int  settings_used;
    bit  tx_idling;
    bit  rx_idling;
    bit  hold_request;

    rfid_card_poll_sequencer u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_read_data  (s_read_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_reg_addr   (m_reg_addr),
        .m_write_data (m_write_data),
        .m_card_valid (m_card_valid),
        .m_card_id    (m_card_id),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [7:0] data);
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_read_data <= data;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(cmd, data);
    endtask

    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic wait_for_results(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_accesses.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [19:0] limit, input logic [7:0] code);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_POLL_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(CFG_POLL_LIMIT, CFG_DATA_W'(limit));
        cfg_index <= CFG_REQUEST_CODE;
        cfg_data  <= CFG_DATA_W'(code);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(CFG_REQUEST_CODE, CFG_DATA_W'(code));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Chip response that steers the poll down its main paths
    function automatic logic [7:0] pick_data();
        logic [7:0]  v;
        int unsigned roll;
        v    = 8'($urandom);
        roll = $urandom_range(0, 9);
        case (sb.step)
            ST_POLL: begin
                if (roll < 6)
                    v = v & ~(IRQ_TIMER_MASK | IRQ_DONE_MASK);
                else if (roll == 6)
                    v = v | IRQ_TIMER_MASK;
                else if (roll == 7)
                    v = (v & ~IRQ_TIMER_MASK) | (IRQ_DONE_MASK & 8'h10);
                else if (roll == 8)
                    v = (v & ~IRQ_TIMER_MASK) | (IRQ_DONE_MASK & 8'h20);
            end
            ST_ERR: begin
                if (roll < 8)
                    v = v & ~ERR_MASK;
            end
            ST_LEVEL: begin
                if (roll < 4)
                    v = 8'd5;
                else if (roll < 6)
                    v = 8'($urandom_range(0, 4));
                else if (roll < 8)
                    v = 8'($urandom_range(6, MAX_RX_BYTES));
            end
            ST_DATA: begin
                // Mostly make the check byte match
                if (sb.rx_index == 4 && roll < 7)
                    v = sb.rx_bytes[0] ^ sb.rx_bytes[1] ^ sb.rx_bytes[2] ^ sb.rx_bytes[3];
            end
            default: ;
        endcase
        return v;
    endfunction

    // Mostly well-formed items, with stray starts and stray data as noise
    task automatic random_item(output bit useful);
        logic       cmd;
        logic [7:0] d;
        if (sb.step == ST_IDLE)
            cmd = ($urandom_range(0, 7) == 0) ? CMD_DATA : CMD_START;
        else
            cmd = ($urandom_range(0, 11) == 0) ? CMD_START : CMD_DATA;
        useful = (sb.step == ST_IDLE) == (cmd == CMD_START);
        d = (useful && cmd == CMD_DATA) ? pick_data() : 8'($urandom);
        send_item(cmd, d);
    endtask

    // Result side: random ready bursts, plus one long hold on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (rx_idling && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_access(m_kind, m_reg_addr, m_write_data, m_card_valid, m_card_id, m_last);
    end

    // Hard stop on a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("run hit the cycle limit with %0d results outstanding",
                 sb.expected_accesses.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [19:0] limit;
        logic [7:0]  code;
        int          useful_n;
        int          k;
        bit          useful;
        bit          quiet;

        sb            = new();
        random_items  = 0;
        settings_used = 0;
        tx_idling     = 1'b0;
        rx_idling     = 1'b0;
        hold_request  = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_START;
        s_read_data   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_POLL_LIMIT;
        cfg_data      = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero poll limit and top request code, stray items, then one whole poll
        write_registers(20'd0, 8'hFF);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_START, 8'hFF);
        send_item(CMD_START, 8'h00);
        foreach (WALK_DATA[i])
            send_item(CMD_DATA, WALK_DATA[i]);
        wait_for_results(SETTLE_CYCLES);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    limit = 20'hFFFFF;
                    code  = 8'h00;
                end
                1: begin
                    limit = 20'd1;
                    code  = 8'($urandom);
                end
                2: begin
                    limit = 20'($urandom_range(2, 6));
                    code  = 8'hFF;
                end
                default: begin
                    limit = POLL_LIMIT_RESET;
                    code  = REQUEST_CODE_RESET;
                end
            endcase
            write_registers(limit, code);
            useful_n = 0;
            k        = 0;
            while (useful_n < PHASE_ITEMS) begin
                // Fill the block against a stalled receiver once
                if (ph == 1 && k == 4)
                    hold_request = 1'b1;
                // Drain the block completely once mid-phase
                if (ph == 2 && k == 15)
                    wait_for_results(0);
                quiet     = (k >= 12 && k < 20);
                tx_idling = (ph != 3) && !quiet;
                rx_idling = tx_idling;
                if (tx_idling && $urandom_range(0, 3) == 0)
                    idle_sender($urandom_range(1, 14));
                random_item(useful);
                if (useful) begin
                    useful_n++;
                    random_items++;
                end
                k++;
            end
            wait_for_results(SETTLE_CYCLES);
        end

        $display("covered %0d accepted items (%0d random), %0d results checked, %0d mismatches",
                 sb.items_taken, random_items, sb.checked, sb.mismatches);
        $display("covered %0d poll reports, %0d with a valid card, under %0d register settings",
                 sb.reports, sb.good_reports, settings_used);
        if (sb.mismatches == 0 && sb.expected_accesses.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rcps_pkg.sv
rtl/core/rfid_card_poll_sequencer.sv
rtl/core/rcps_checker.sv
bench/poll_scoreboard_pkg.sv
bench/rfid_card_poll_sequencer_tb.sv
